@@ src/rmgu_pkg.sv @@
// Shared types, constants and helper functions for the rotation matrix gyro update block.
// Every module of the block imports this package; it depends on nothing else.
`default_nettype none

package rmgu_pkg;

  localparam int VAL_W         = 18;
  localparam int NUM_ROWS      = 3;
  localparam int ROW_W         = 3 * VAL_W;
  localparam int FRAC_BITS_DEF = 16;
  // Words accepted but not yet delivered: one in the output register, one in the collector.
  localparam int MAX_INFLIGHT  = 2;

  localparam int IN_DATA_W  = ((ROW_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = ((NUM_ROWS * ROW_W + 7) / 8) * 8;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [1:0] row_idx_t;

  localparam row_idx_t ROW_A = 2'd0;
  localparam row_idx_t ROW_B = 2'd1;
  localparam row_idx_t ROW_C = 2'd2;

  localparam logic ACT_INTEGRATE = 1'b0;
  localparam logic ACT_LOAD      = 1'b1;

  localparam val_t VAL_MAX = 18'sh1FFFF;
  localparam val_t VAL_MIN = 18'sh20000;

  // Element x sits in the lowest bits.
  typedef struct packed {
    val_t z;
    val_t y;
    val_t x;
  } row_t;

  // One row operation handed from the sequencer to memory and datapath.
  typedef struct packed {
    logic     action;
    row_idx_t sel;
    row_idx_t row;
    row_t     vec;
  } issue_t;

  // A finished row: written back to memory and collected for the output.
  typedef struct packed {
    logic     valid;
    row_idx_t row;
    row_t     data;
  } row_wr_t;

  // 1.0 in the chosen format, clipped when it does not fit.
  function automatic val_t unit_value(int frac);
    if (frac >= VAL_W - 1) begin
      return VAL_MAX;
    end
    return val_t'(1 << frac);
  endfunction

  function automatic row_t identity_row(row_idx_t row, int frac);
    row_t r;
    r = '0;
    case (row)
      ROW_A: begin
        r.x = unit_value(frac);
      end
      ROW_B: begin
        r.y = unit_value(frac);
      end
      ROW_C: begin
        r.z = unit_value(frac);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/rotation_matrix_gyro_update.sv @@
// Attitude direction-cosine matrix with first-order gyro integration. Each accepted word
// either integrates one gyro angle increment (every row r becomes r + r x g, rounded and
// saturated to Q2.16) or loads one row, and returns the whole updated matrix as one word.
// Words are accepted only while the row sequencer is idle: the matrix lives in a three-row
// memory with a single read port, and each word walks through the rows one per cycle. The
// result is registered once its last row is written back. Up to two words may be
// outstanding, so a new word is taken while a finished result still waits on the output.
// After reset the matrix is the identity; no clearing pass is needed.
// Depends on rmgu_pkg, rmgu_row_mem, rmgu_row_calc and rmgu_out_buf.
`default_nettype none

module rotation_matrix_gyro_update #(
  parameter int FRAC_BITS = rmgu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // vec_x, vec_y, vec_z from bit 0 up, zero padded
  input  logic [rmgu_pkg::IN_DATA_W-1:0]  s_tdata,
  // action, row_select from bit 0 up
  input  logic [rmgu_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // row_a_x, row_a_y, row_a_z, row_b_x, ... row_c_z from bit 0 up, zero padded
  output logic [rmgu_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rmgu_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ROW_B = 2'd1;
  localparam logic [1:0] PH_ROW_C = 2'd2;

  localparam int CNT_W = $clog2(MAX_INFLIGHT + 1);

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;
  logic             delivered;
  logic             issue_valid;
  issue_t           issue;
  issue_t           held;
  row_t             old_row;
  row_wr_t          wr;

  assign s_tready = (phase == PH_IDLE) && (cnt < CNT_W'(MAX_INFLIGHT));
  assign accept   = s_tvalid && s_tready;
  assign cnt_next = cnt + CNT_W'(accept) - CNT_W'(delivered);

  always_comb begin
    issue       = held;
    issue.row   = ROW_A;
    issue_valid = 1'b0;
    phase_next  = phase;
    case (phase)
      PH_IDLE: begin
        if (accept) begin
          issue.action = s_tuser[0];
          issue.sel    = s_tuser[2:1];
          issue.vec    = s_tdata[ROW_W-1:0];
          issue_valid  = 1'b1;
          phase_next   = PH_ROW_B;
        end
      end
      PH_ROW_B: begin
        issue.row   = ROW_B;
        issue_valid = 1'b1;
        phase_next  = PH_ROW_C;
      end
      PH_ROW_C: begin
        issue.row   = ROW_C;
        issue_valid = 1'b1;
        phase_next  = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= issue;
    end
  end

  // A row is read again no earlier than the cycle after its write-back,
  // so reads never overlap a pending write of the same row.
  rmgu_row_mem #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (issue.row),
    .rd_row  (old_row),
    .wr      (wr)
  );

  rmgu_row_calc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_calc (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue       (issue),
    .old_row     (old_row),
    .wr          (wr)
  );

  rmgu_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .delivered (delivered)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_INFLIGHT))
    else $error("outstanding word count above limit");

  a_deliver_counted: assert property (@(posedge clk) disable iff (rst)
    delivered |-> (cnt != '0))
    else $error("word delivered with none outstanding");

  a_row_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase == PH_ROW_B) && !s_tready ##1 (phase == PH_ROW_C))
    else $error("row sequence broken after accept");

endmodule

`default_nettype wire

@@ src/rmgu_row_mem.sv @@
// Row memory of the attitude matrix: three rows, one write and one registered read per cycle.
// Uses rmgu_pkg; rows never written since reset read as the identity matrix.
`default_nettype none

module rmgu_row_mem #(
  parameter int FRAC_BITS = rmgu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rmgu_pkg::row_idx_t rd_addr,
  output rmgu_pkg::row_t     rd_row,
  input  rmgu_pkg::row_wr_t  wr
);
  import rmgu_pkg::*;

  row_t                mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] vld;
  row_t                mem_rd;
  logic                rd_vld;
  row_idx_t            rd_addr_q;

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.row] <= wr.data;
    end
    mem_rd    <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.valid) begin
        vld[wr.row] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_row = rd_vld ? mem_rd : identity_row(rd_addr_q, FRAC_BITS);

endmodule

`default_nettype wire

@@ src/rmgu_row_calc.sv @@
// Row datapath: six products in one stage, then rounding, accumulation and saturation.
// Uses rmgu_pkg; takes the old row from rmgu_row_mem in the cycle after the issue.
`default_nettype none

module rmgu_row_calc #(
  parameter int FRAC_BITS = rmgu_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              issue_valid,
  input  rmgu_pkg::issue_t  issue,
  input  rmgu_pkg::row_t    old_row,
  output rmgu_pkg::row_wr_t wr
);
  import rmgu_pkg::*;

  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam acc_t HALF    = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t ACC_MAX = acc_t'(VAL_MAX);
  localparam acc_t ACC_MIN = acc_t'(VAL_MIN);

  // Adding half an LSB before the arithmetic shift rounds ties toward plus infinity.
  function automatic val_t elem_next(val_t old, prod_t pa, prod_t pb);
    acc_t diff;
    acc_t term;
    acc_t sum;
    diff = acc_t'(pa) - acc_t'(pb) + HALF;
    term = diff >>> FRAC_BITS;
    sum  = term + acc_t'(old);
    if (sum > ACC_MAX) begin
      return VAL_MAX;
    end
    if (sum < ACC_MIN) begin
      return VAL_MIN;
    end
    return val_t'(sum[VAL_W-1:0]);
  endfunction

  logic   s1_valid;
  issue_t s1;
  logic   s2_valid;
  issue_t s2;
  row_t   s2_old;
  prod_t  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  row_t   integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1     <= issue;
    s2     <= s1;
    s2_old <= old_row;
    p_yz   <= old_row.y * s1.vec.z;
    p_zy   <= old_row.z * s1.vec.y;
    p_zx   <= old_row.z * s1.vec.x;
    p_xz   <= old_row.x * s1.vec.z;
    p_xy   <= old_row.x * s1.vec.y;
    p_yx   <= old_row.y * s1.vec.x;
  end

  always_comb begin
    integ.x = elem_next(s2_old.x, p_yz, p_zy);
    integ.y = elem_next(s2_old.y, p_zx, p_xz);
    integ.z = elem_next(s2_old.z, p_xy, p_yx);

    wr.valid = s2_valid;
    wr.row   = s2.row;
    if (s2.action == ACT_LOAD) begin
      wr.data = (s2.sel == s2.row) ? s2.vec : s2_old;
    end else begin
      wr.data = integ;
    end
  end

endmodule

`default_nettype wire

@@ src/rmgu_out_buf.sv @@
// Output side: collects the three finished rows of a word and holds the result word.
// Uses rmgu_pkg; a completed word waits in the collector while the output register is full.
`default_nettype none

module rmgu_out_buf (
  input  logic                              clk,
  input  logic                              rst,
  input  rmgu_pkg::row_wr_t                 wr,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rmgu_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              delivered
);
  import rmgu_pkg::*;

  localparam int PAD_W = OUT_DATA_W - NUM_ROWS * ROW_W;

  row_t coll_a, coll_b, coll_c;
  row_t out_a, out_b, out_c;
  logic pend;
  logic out_free;
  logic last;

  assign out_free  = !m_tvalid || m_tready;
  assign last      = wr.valid && (wr.row == ROW_C);
  assign delivered = m_tvalid && m_tready;
  assign m_tdata   = {{PAD_W{1'b0}}, out_c, out_b, out_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else if (pend) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
        pend     <= 1'b0;
      end
    end else if (last) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
      end else begin
        pend <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid && (wr.row == ROW_A)) begin
      coll_a <= wr.data;
    end
    if (wr.valid && (wr.row == ROW_B)) begin
      coll_b <= wr.data;
    end
    if (last) begin
      coll_c <= wr.data;
    end
    if (pend && out_free) begin
      out_a <= coll_a;
      out_b <= coll_b;
      out_c <= coll_c;
    end else if (last && !pend && out_free) begin
      out_a <= coll_a;
      out_b <= coll_b;
      out_c <= wr.data;
    end
  end

  // The admission limit keeps new rows away while a finished word waits in the collector.
  a_no_row_while_pending: assert property (@(posedge clk) disable iff (rst)
    !(pend && wr.valid))
    else $error("row arrived while a finished word waits in the collector");

  // The rows of one word arrive in consecutive cycles, row a first.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (wr.valid && (wr.row == ROW_A)) |=> (wr.valid && (wr.row == ROW_B)))
    else $error("row b did not follow row a");

endmodule

`default_nettype wire
